>>> design/iacp_pkg.sv
// Shared types and constants of the install archive chain parser.
// Used by iacp_front, iacp_queue, iacp_back and the top level.
package iacp_pkg;

    localparam logic [7:0] NAME_LEN_BYTE = 8'h0C;
    localparam logic [7:0] MARK_BYTE     = 8'h24;
    localparam logic [7:0] SPACE_BYTE    = 8'h20;
    localparam int unsigned HDR_LEN      = 27;
    localparam int unsigned TRAILER_LEN  = 5;
    localparam int unsigned MIN_SPAN     = 32;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_BITS    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] RST_ARCHIVE_LENGTH = 32'd32;
    localparam logic [31:0] RST_START_OFFSET   = 32'd0;
    localparam logic [16:0] RST_MAX_COUNT      = 17'd100000;
    localparam logic [30:0] RST_MAX_SIZE       = 31'd268435456;

    typedef enum logic [1:0] {
        REG_ARCHIVE_LENGTH = 2'd0,
        REG_START_OFFSET   = 2'd1,
        REG_MAX_COUNT      = 2'd2,
        REG_MAX_SIZE       = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        FAIL_NONE      = 3'd0,
        FAIL_TOO_SHORT = 3'd1,
        FAIL_RECORD    = 3'd2,
        FAIL_TAIL      = 3'd3,
        FAIL_NO_MEMBER = 3'd4,
        FAIL_LIMIT     = 3'd5
    } fail_t;

    typedef struct packed {
        logic [31:0] archive_length;
        logic [31:0] start_offset;
        logic [16:0] max_count;
        logic [30:0] max_size;
    } cfg_t;

    // One queue entry: everything one byte causes (member and/or verdict).
    typedef struct packed {
        logic        has_member;
        logic        has_verdict;
        logic [16:0] member_number;
        logic [32:0] header_position;
        logic [30:0] packed_size;
        logic [30:0] unpacked_size;
        logic        pack_method;
        logic [31:0] dos_stamp;
        logic        archive_ok;
        logic [16:0] members_total;
        logic [2:0]  fail_reason;
    } event_t;

endpackage

>>> design/iacp_front.sv
// Front part: accepts archive bytes, walks the header/payload chain and
// posts one event per byte that yields results. Depends on iacp_pkg.
module iacp_front
    import iacp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         take,
    input  logic [7:0]   data_byte,
    output logic         push,
    output event_t       ev
);

    localparam int SW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 2;

    typedef enum logic [2:0] {
        PH_HEADER, PH_PRELUDE, PH_PAYLOAD, PH_TAIL, PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] chain_end_reg, chain_end_next;
    logic [31:0]            rem_reg, rem_next;
    logic [4:0]             idx_reg, idx_next;
    logic [16:0]            cnt_reg, cnt_next;
    logic                   nonspace_reg, nonspace_next;
    logic                   broken_reg, broken_next;
    logic                   limit_reg, limit_next;
    logic                   first_reg, first_next;
    logic [7:0]             hb_reg [13];

    logic [31:0]   cs, us, stamp, rem_dec;
    logic [SW-1:0] alen_ext, end_hdr, end_mem, end_next_ext;
    logic          bad, bad_j, accept, do_break;
    logic [2:0]    reason;
    logic [3:0]    hb_idx;

    assign cs       = {hb_reg[3], hb_reg[2], hb_reg[1], hb_reg[0]};
    assign us       = {hb_reg[7], hb_reg[6], hb_reg[5], hb_reg[4]};
    assign stamp    = {hb_reg[11], hb_reg[10], hb_reg[9], hb_reg[8]};
    assign alen_ext = SW'(cfg.archive_length);
    assign end_hdr  = SW'(chain_end_reg) + SW'(HDR_LEN);
    assign end_mem  = end_hdr + SW'(cs);
    assign hb_idx   = 4'(idx_reg - 5'd13);

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        chain_end_next = chain_end_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        nonspace_next  = nonspace_reg;
        broken_next    = broken_reg;
        limit_next     = limit_reg;
        first_next     = first_reg;
        bad            = 1'b0;
        accept         = 1'b0;
        do_break       = 1'b0;
        rem_dec        = (rem_reg != 32'd0) ? rem_reg - 32'd1 : rem_reg;
        bad_j = (data_byte != MARK_BYTE) || cs[31] || us[31]
             || (cs > {1'b0, cfg.max_size}) || (us > {1'b0, cfg.max_size})
             || (hb_reg[12] > 8'd1)
             || ((hb_reg[12] == 8'd0) && (cs != us))
             || (end_mem > alen_ext)
             || ((hb_reg[12] == 8'd1) && (cs < 32'd3));
        ev     = '0;
        reason = FAIL_NONE;

        if (take && phase_reg != PH_DONE) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (idx_reg == 5'd0) begin
                        if (end_hdr > alen_ext) begin
                            phase_next = PH_TAIL;
                        end else if (cnt_reg >= cfg.max_count) begin
                            limit_next = 1'b1;
                            phase_next = PH_TAIL;
                        end else begin
                            nonspace_next = 1'b0;
                            bad = (data_byte != NAME_LEN_BYTE);
                        end
                    end else if (idx_reg <= 5'd12) begin
                        bad = (data_byte < SPACE_BYTE);
                        if (data_byte != SPACE_BYTE) nonspace_next = 1'b1;
                        if (idx_reg == 5'd12 && !nonspace_reg && data_byte == SPACE_BYTE)
                            bad = 1'b1;
                    end
                    if (phase_next == PH_HEADER) begin
                        if (bad) begin
                            do_break = 1'b1;
                        end else if (idx_reg == 5'(HDR_LEN - 1)) begin
                            idx_next = 5'd0;
                            if (bad_j) begin
                                do_break = 1'b1;
                            end else begin
                                rem_next = cs;
                                if (hb_reg[12] == 8'd1) begin
                                    phase_next = PH_PRELUDE;
                                    first_next = 1'b1;
                                end else begin
                                    accept     = 1'b1;
                                    phase_next = (cs != 32'd0) ? PH_PAYLOAD : PH_HEADER;
                                end
                            end
                        end else begin
                            idx_next = idx_reg + 5'd1;
                        end
                    end
                end
                PH_PRELUDE: begin
                    if (first_reg) begin
                        if (data_byte > 8'd1) begin
                            do_break = 1'b1;
                        end else begin
                            rem_next   = rem_reg - 32'd1;
                            first_next = 1'b0;
                        end
                    end else if (data_byte < 8'd4 || data_byte > 8'd6) begin
                        do_break = 1'b1;
                    end else begin
                        rem_next   = rem_reg - 32'd1;
                        accept     = 1'b1;
                        phase_next = (rem_reg != 32'd1) ? PH_PAYLOAD : PH_HEADER;
                    end
                end
                PH_PAYLOAD: begin
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0) phase_next = PH_HEADER;
                end
                default: begin
                end
            endcase

            if (do_break) begin
                broken_next = 1'b1;
                phase_next  = PH_TAIL;
                idx_next    = 5'd0;
            end

            if (accept) begin
                ev.has_member      = 1'b1;
                ev.member_number   = cnt_reg;
                ev.header_position = 33'(SW'(cfg.start_offset) + SW'(chain_end_reg));
                ev.packed_size     = cs[30:0];
                ev.unpacked_size   = us[30:0];
                ev.pack_method     = hb_reg[12][0];
                ev.dos_stamp       = stamp;
                cnt_next           = cnt_reg + 17'd1;
                chain_end_next     = end_mem[LENGTH_BITS-1:0];
            end

            pos_next = pos_reg + LENGTH_BITS'(1);
            end_next_ext = SW'(chain_end_next);
            if (SW'(pos_next) == alen_ext) begin
                if (cfg.archive_length < 32'(MIN_SPAN))      reason = FAIL_TOO_SHORT;
                else if (limit_next)                         reason = FAIL_LIMIT;
                else if (cnt_next == 17'd0)                  reason = FAIL_NO_MEMBER;
                else if (broken_next)                        reason = FAIL_RECORD;
                else if (end_next_ext != alen_ext &&
                         end_next_ext + SW'(TRAILER_LEN) != alen_ext)
                                                             reason = FAIL_TAIL;
                else                                         reason = FAIL_NONE;
                ev.has_verdict   = 1'b1;
                ev.archive_ok    = (reason == FAIL_NONE);
                ev.members_total = cnt_next;
                ev.fail_reason   = reason;
                phase_next       = PH_DONE;
            end
        end else begin
            end_next_ext = SW'(chain_end_reg);
        end
    end

    assign push = ev.has_member || ev.has_verdict;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            chain_end_reg <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            nonspace_reg  <= 1'b0;
            broken_reg    <= 1'b0;
            limit_reg     <= 1'b0;
            first_reg     <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            chain_end_reg <= chain_end_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            nonspace_reg  <= nonspace_next;
            broken_reg    <= broken_next;
            limit_reg     <= limit_next;
            first_reg     <= first_next;
        end
    end

    // Hold header bytes 13..25; byte 26 (marker) is judged on arrival.
    always_ff @(posedge aclk) begin
        if (take && phase_reg == PH_HEADER && idx_reg >= 5'd13
                && idx_reg < 5'(HDR_LEN - 1))
            hb_reg[hb_idx] <= data_byte;
    end

endmodule

>>> design/iacp_queue.sv
// Short event queue between the front and back parts.
// Depends on iacp_pkg.
module iacp_queue
    import iacp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t push_ev,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output event_t head
);

    event_t               mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [QPTR_BITS:0]   cnt_reg;

    assign full  = (cnt_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
        end
    end

endmodule

>>> design/iacp_back.sv
// Back part: splits queued events into result items and holds them in an
// output register. Depends on iacp_pkg.
module iacp_back
    import iacp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         empty,
    input  event_t       head,
    output logic         pop,
    input  logic         m_ready,
    output logic         m_valid,
    output logic         m_result_kind,
    output logic [16:0]  m_member_number,
    output logic [32:0]  m_header_position,
    output logic [30:0]  m_packed_size,
    output logic [30:0]  m_unpacked_size,
    output logic         m_pack_method,
    output logic [31:0]  m_dos_stamp,
    output logic         m_archive_ok,
    output logic [16:0]  m_members_total,
    output logic [2:0]   m_fail_reason,
    output logic         m_last_of_run
);

    logic   valid_reg, half_reg, load, show_member;
    event_t out_reg, out_next;
    logic   kind_reg, last_reg;

    assign load        = !valid_reg || m_ready;
    assign show_member = head.has_member && !half_reg;
    assign pop         = load && !empty && !(show_member && head.has_verdict);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else if (load) begin
            valid_reg <= !empty;
            if (!empty) half_reg <= show_member && head.has_verdict;
        end
    end

    // Zero the fields that do not belong to the kind shown.
    always_comb begin
        out_next = '0;
        if (show_member) begin
            out_next.member_number   = head.member_number;
            out_next.header_position = head.header_position;
            out_next.packed_size     = head.packed_size;
            out_next.unpacked_size   = head.unpacked_size;
            out_next.pack_method     = head.pack_method;
            out_next.dos_stamp       = head.dos_stamp;
        end else begin
            out_next.archive_ok      = head.archive_ok;
            out_next.members_total   = head.members_total;
            out_next.fail_reason     = head.fail_reason;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            out_reg  <= out_next;
            kind_reg <= !show_member;
            last_reg <= show_member ? !head.has_verdict : 1'b1;
        end
    end

    assign m_valid           = valid_reg;
    assign m_result_kind     = kind_reg;
    assign m_member_number   = out_reg.member_number;
    assign m_header_position = out_reg.header_position;
    assign m_packed_size     = out_reg.packed_size;
    assign m_unpacked_size   = out_reg.unpacked_size;
    assign m_pack_method     = out_reg.pack_method;
    assign m_dos_stamp       = out_reg.dos_stamp;
    assign m_archive_ok      = out_reg.archive_ok;
    assign m_members_total   = out_reg.members_total;
    assign m_fail_reason     = out_reg.fail_reason;
    assign m_last_of_run     = last_reg;

endmodule

>>> design/install_archive_chain_parser.sv
// Top level of the install archive chain parser: configuration registers,
// front parser, event queue and result stage. Depends on iacp_pkg.
//
// Usage:
//   s_valid/s_ready/s_data_byte carry archive bytes in file order, one item
//   per accepted cycle. The parser takes one byte every cycle while the
//   event queue has room, so the sustained rate is one byte per cycle.
//   m_valid/m_ready carry result items: a member record when a header (and
//   for imploded members, its two prelude bytes) checks out, and a verdict
//   on the byte that reaches archive_length. A byte can yield both; the
//   member comes first, and m_last_of_run marks the last item of a byte.
//   Path: a result's event enters the queue when its byte is accepted and
//   then moves to the output register, from where it shows on m_*; a byte
//   yielding two items shows them one after the other.
//   When the receiver stalls, up to four events wait in the queue; once it
//   is full, s_ready drops until the output side drains.
//   cfg_valid/cfg_index/cfg_data write a register; cfg_ready is always high.
//   Write configuration only while the block is idle.
//   Reset (aresetn low, synchronous) restores register defaults, clears the
//   chain state and empties the queue and output stage. After the verdict,
//   further bytes are accepted and dropped until the next reset.
module install_archive_chain_parser
    import iacp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_result_kind,
    output logic [16:0]  m_member_number,
    output logic [32:0]  m_header_position,
    output logic [30:0]  m_packed_size,
    output logic [30:0]  m_unpacked_size,
    output logic         m_pack_method,
    output logic [31:0]  m_dos_stamp,
    output logic         m_archive_ok,
    output logic [16:0]  m_members_total,
    output logic [2:0]   m_fail_reason,
    output logic         m_last_of_run
);

    cfg_t   cfg_reg;
    logic   push, pop, full, empty, take;
    event_t push_ev, head;

    assign cfg_ready = 1'b1;
    assign s_ready   = !full;
    assign take      = s_valid && s_ready;

    // Register file: one write per handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.archive_length <= RST_ARCHIVE_LENGTH;
            cfg_reg.start_offset   <= RST_START_OFFSET;
            cfg_reg.max_count      <= RST_MAX_COUNT;
            cfg_reg.max_size       <= RST_MAX_SIZE;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_ARCHIVE_LENGTH: cfg_reg.archive_length <= cfg_data;
                REG_START_OFFSET:   cfg_reg.start_offset   <= cfg_data;
                REG_MAX_COUNT:      cfg_reg.max_count      <= cfg_data[16:0];
                REG_MAX_SIZE:       cfg_reg.max_size       <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Front: classify each byte, post events.
    iacp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .take      (take),
        .data_byte (s_data_byte),
        .push      (push),
        .ev        (push_ev)
    );

    // Queue: lets the parser run on while results wait.
    iacp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_ev (push_ev),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .head    (head)
    );

    // Back: split events into items, hold them for the receiver.
    iacp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .empty             (empty),
        .head              (head),
        .pop               (pop),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_result_kind     (m_result_kind),
        .m_member_number   (m_member_number),
        .m_header_position (m_header_position),
        .m_packed_size     (m_packed_size),
        .m_unpacked_size   (m_unpacked_size),
        .m_pack_method     (m_pack_method),
        .m_dos_stamp       (m_dos_stamp),
        .m_archive_ok      (m_archive_ok),
        .m_members_total   (m_members_total),
        .m_fail_reason     (m_fail_reason),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

>>> bench/install_archive_chain_parser_tb.sv
// Self-checking bench for install_archive_chain_parser: streams archive
// bytes, predicts member records and the verdict, compares every result.
// Depends on iacp_pkg and the design top level.
module install_archive_chain_parser_tb;
    import iacp_pkg::*;

    typedef enum int {PH_HEADER, PH_PRELUDE, PH_PAYLOAD, PH_TAIL, PH_DONE} parse_phase_e;
    typedef enum int {HDR_BAD, HDR_ACCEPT, HDR_PRELUDE} header_check_e;

    typedef struct {
        bit        kind;
        bit [16:0] num;
        bit [32:0] hpos;
        bit [30:0] psz;
        bit [30:0] usz;
        bit        meth;
        bit [31:0] stamp;
        bit        ok;
        bit [16:0] total;
        bit [2:0]  reason;
        bit        last;
    } chain_result_t;

    // Tracks the header chain byte by byte and holds the results still owed.
    class chain_scoreboard;
        longint unsigned arc_len = RST_ARCHIVE_LENGTH, base_off = RST_START_OFFSET;
        longint unsigned max_cnt = RST_MAX_COUNT, max_sz = RST_MAX_SIZE;
        longint unsigned pos, remaining, next_hdr;
        parse_phase_e    phase = PH_HEADER;
        int unsigned     hidx, count;
        bit [7:0]        hb[14];
        bit              nonspace, broken, limit;
        chain_result_t   want[$];
        int              errors;

        function void set_reg(reg_index_t i, bit [31:0] d);
            case (i)
                REG_ARCHIVE_LENGTH: arc_len = d;
                REG_START_OFFSET:   base_off = d;
                REG_MAX_COUNT:      max_cnt = d[16:0];
                REG_MAX_SIZE:       max_sz = d[30:0];
                default: ;
            endcase
        endfunction

        function longint unsigned field32(int unsigned at);
            return {hb[at+3], hb[at+2], hb[at+1], hb[at]};
        endfunction

        function void cut();
            broken = 1;
            phase = PH_TAIL;
            hidx = 0;
        endfunction

        function header_check_e judge();
            longint unsigned cs, us;
            cs = field32(0);
            us = field32(4);
            if (hb[13] != MARK_BYTE) return HDR_BAD;
            if (cs[31] || us[31]) return HDR_BAD;
            if (cs > max_sz || us > max_sz) return HDR_BAD;
            if (hb[12] > 1) return HDR_BAD;
            if (hb[12] == 0 && cs != us) return HDR_BAD;
            if (next_hdr + HDR_LEN + cs > arc_len) return HDR_BAD;
            if (hb[12] == 0) return HDR_ACCEPT;
            if (cs < 3) return HDR_BAD;
            return HDR_PRELUDE;
        endfunction

        function chain_result_t member_record();
            chain_result_t r;
            longint unsigned cs;
            r = '{default: 0};
            cs = field32(0);
            r.num = 17'(count);
            r.hpos = 33'(base_off + next_hdr);
            r.psz = cs[30:0];
            r.usz = 31'(field32(4));
            r.meth = hb[12][0];
            r.stamp = 32'(field32(8));
            count = (count + 1) & 32'h1FFFF;
            next_hdr = (next_hdr + HDR_LEN + cs) & 32'hFFFFFFFF;
            return r;
        endfunction

        function void note_byte(bit [7:0] b);
            chain_result_t got[$];
            chain_result_t v;
            bit bad;
            header_check_e hc;
            int unsigned i;
            fail_t why;
            if (phase == PH_DONE) return;
            bad = 0;
            case (phase)
                PH_HEADER: begin
                    i = hidx;
                    if (i == 0) begin
                        if (next_hdr + HDR_LEN > arc_len) begin
                            phase = PH_TAIL;
                        end else if (count >= max_cnt) begin
                            limit = 1;
                            phase = PH_TAIL;
                        end else begin
                            nonspace = 0;
                            bad = (b != NAME_LEN_BYTE);
                        end
                    end else if (i <= 12) begin
                        if (b < SPACE_BYTE) bad = 1;
                        if (b != SPACE_BYTE) nonspace = 1;
                        if (i == 12 && !nonspace) bad = 1;
                    end else begin
                        hb[i-13] = b;
                    end
                    if (phase == PH_HEADER) begin
                        if (bad) begin
                            cut();
                        end else begin
                            hidx = (i + 1) & 31;
                            if (hidx >= HDR_LEN) begin
                                hc = judge();
                                hidx = 0;
                                if (hc == HDR_BAD) begin
                                    cut();
                                end else if (hc == HDR_PRELUDE) begin
                                    remaining = field32(0);
                                    phase = PH_PRELUDE;
                                end else begin
                                    remaining = field32(0);
                                    got.push_back(member_record());
                                    phase = remaining ? PH_PAYLOAD : PH_HEADER;
                                end
                            end
                        end
                    end
                end
                PH_PRELUDE: begin
                    if (remaining == field32(0)) begin
                        if (b > 1) cut();
                        else remaining--;
                    end else if (b < 4 || b > 6) begin
                        cut();
                    end else begin
                        remaining--;
                        got.push_back(member_record());
                        phase = remaining ? PH_PAYLOAD : PH_HEADER;
                    end
                end
                PH_PAYLOAD: begin
                    if (remaining) remaining--;
                    if (remaining == 0) phase = PH_HEADER;
                end
                default: ;
            endcase
            pos = (pos + 1) & 32'hFFFFFFFF;
            if (pos == arc_len) begin
                if (arc_len < MIN_SPAN) why = FAIL_TOO_SHORT;
                else if (limit) why = FAIL_LIMIT;
                else if (count == 0) why = FAIL_NO_MEMBER;
                else if (broken) why = FAIL_RECORD;
                else if (next_hdr != arc_len && next_hdr + TRAILER_LEN != arc_len)
                    why = FAIL_TAIL;
                else why = FAIL_NONE;
                v = '{default: 0};
                v.kind = 1;
                v.ok = (why == FAIL_NONE);
                v.total = 17'(count);
                v.reason = why;
                got.push_back(v);
                phase = PH_DONE;
            end
            foreach (got[k]) begin
                got[k].last = (k == got.size() - 1);
                want.push_back(got[k]);
            end
        endfunction

        function void diff(string f, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t: %s expected %0h actual %0h", $time, f, e, a);
                errors++;
            end
        endfunction

        function void check(chain_result_t g);
            chain_result_t e;
            if (want.size() == 0) begin
                $display("%0t: unexpected result, kind %0d", $time, g.kind);
                errors++;
                return;
            end
            e = want.pop_front();
            diff("result_kind", e.kind, g.kind);
            diff("member_number", e.num, g.num);
            diff("header_position", e.hpos, g.hpos);
            diff("packed_size", e.psz, g.psz);
            diff("unpacked_size", e.usz, g.usz);
            diff("pack_method", e.meth, g.meth);
            diff("dos_stamp", e.stamp, g.stamp);
            diff("archive_ok", e.ok, g.ok);
            diff("members_total", e.total, g.total);
            diff("fail_reason", e.reason, g.reason);
            diff("last_of_run", e.last, g.last);
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 1000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_result_kind, m_pack_method, m_archive_ok, m_last_of_run;
    logic [16:0] m_member_number, m_members_total;
    logic [32:0] m_header_position;
    logic [30:0] m_packed_size, m_unpacked_size;
    logic [31:0] m_dos_stamp;
    logic [2:0]  m_fail_reason;

    chain_scoreboard sb = new();
    bit          no_gaps;      // burst mode: neither side idles
    bit          hold_req;     // ask the receiver for one long stall
    int          hold_left, stall_left, cycles, bytes_sent;

    install_archive_chain_parser u_top (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Bail out if the run hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("install_archive_chain_parser test failed");
            $finish;
        end
    end

    // Receiver: check each accepted result, then draw the next stall.
    always @(posedge aclk) begin
        chain_result_t g;
        if (aresetn && m_valid && m_ready) begin
            g.kind = m_result_kind;     g.num = m_member_number;
            g.hpos = m_header_position; g.psz = m_packed_size;
            g.usz = m_unpacked_size;    g.meth = m_pack_method;
            g.stamp = m_dos_stamp;      g.ok = m_archive_ok;
            g.total = m_members_total;  g.reason = m_fail_reason;
            g.last = m_last_of_run;
            sb.check(g);
            stall_left = no_gaps ? 0 : $urandom_range(0, 5);
        end
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    // Offer one item; keep valid high across back-to-back items.
    task automatic send_byte(bit [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic cfg_write(reg_index_t idx, bit [31:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, d);
    endtask

    // Drain all owed results, then let the pipeline empty.
    task automatic settle();
        cfg_valid <= 0;
        s_valid <= 0;
        while (sb.want.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic put32(bit [31:0] v);
        for (int k = 0; k < 4; k++) send_byte(v[8*k +: 8]);
    endtask

    // name_mode: 0 printable, 1 all spaces, 2 one control byte.
    task automatic send_header(bit [7:0] lb, int name_mode, bit [31:0] cs, bit [31:0] us,
                               bit [7:0] meth, bit [31:0] stamp, bit [7:0] mark);
        int ctl;
        ctl = $urandom_range(0, 11);
        send_byte(lb);
        for (int k = 0; k < 12; k++) begin
            if (name_mode == 1) send_byte(SPACE_BYTE);
            else if (name_mode == 2 && k == ctl) send_byte($urandom_range(0, 31));
            else if (k == 0) send_byte(SPACE_BYTE);
            else send_byte($urandom_range(32, 255));
        end
        put32(cs);
        put32(us);
        put32(stamp);
        send_byte(meth);
        send_byte(mark);
    endtask

    task automatic send_payload(int unsigned cs, bit meth, bit [7:0] p0, bit [7:0] p1);
        for (int unsigned k = 0; k < cs; k++) begin
            if (meth && k == 0) send_byte(p0);
            else if (meth && k == 1) send_byte(p1);
            else send_byte($urandom);
        end
    endtask

    task automatic good_member(int unsigned cs, bit meth, bit [31:0] stamp);
        bit [31:0] us;
        us = meth ? ($urandom % (sb.max_sz + 1)) : cs;
        send_header(NAME_LEN_BYTE, 0, cs, us, meth, stamp, MARK_BYTE);
        send_payload(cs, meth, $urandom_range(0, 1), $urandom_range(4, 6));
    endtask

    task automatic rand_member();
        bit meth;
        int unsigned top;
        top = (sb.max_sz < 12) ? sb.max_sz : 12;
        meth = (top >= 3) && $urandom_range(0, 2) == 0;
        good_member(meth ? $urandom_range(3, top) : $urandom_range(0, top), meth, $urandom);
    endtask

    initial begin
        int unsigned cs, sel, c;
        bit [7:0] p1;
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // Extremes: span never reached, widest offset, count and size.
        cfg_write(REG_ARCHIVE_LENGTH, 32'hFFFFFFFF);
        cfg_write(REG_START_OFFSET, 32'hFFFFFFFF);
        cfg_write(REG_MAX_COUNT, 32'h1FFFF);
        cfg_write(REG_MAX_SIZE, 32'h7FFFFFFF);
        cfg_valid <= 0;

        // Directed members: empty stored, stamp extremes, each prelude form.
        good_member(0, 0, 32'h0);
        good_member(5, 0, 32'hFFFFFFFF);
        send_header(NAME_LEN_BYTE, 0, 3, 32'h7FFFFFFF, 1, 32'h12345678, MARK_BYTE);
        send_payload(3, 1, 0, 4);
        send_header(NAME_LEN_BYTE, 0, 4, 0, 1, 32'hA5A55A5A, MARK_BYTE);
        send_payload(4, 1, 1, 6);
        send_header(NAME_LEN_BYTE, 0, 5, 9, 1, 32'h0, MARK_BYTE);
        send_payload(5, 1, 0, 5);
        good_member(1, 0, $urandom);
        settle();

        // Zero size ceiling: only empty stored members pass.
        cfg_write(REG_START_OFFSET, 32'h0);
        cfg_write(REG_MAX_SIZE, 32'h0);
        cfg_valid <= 0;
        good_member(0, 0, $urandom);
        good_member(0, 0, $urandom);
        settle();

        // Touch the low extremes, then restore before more bytes.
        cfg_write(REG_ARCHIVE_LENGTH, 32'h1);
        cfg_write(REG_MAX_COUNT, 32'h1);
        cfg_write(REG_ARCHIVE_LENGTH, 32'hFFFFFFFF);
        cfg_write(REG_MAX_COUNT, 32'h1FFFF);
        cfg_write(REG_MAX_SIZE, 32'd12);
        cfg_write(REG_START_OFFSET, $urandom);
        cfg_valid <= 0;

        // Random well-formed chain with varying idling and settings.
        while (bytes_sent < 900) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if (bytes_sent > 400 && !hold_left && sb.count % 10 == 1) hold_req = 1;
            rand_member();
            if (sb.count % 10 == 0) begin
                settle();
                cfg_write(REG_START_OFFSET, $urandom);
                cfg_write(REG_MAX_SIZE, $urandom_range(12, 32'h7FFFFFFF));
                cfg_valid <= 0;
            end
        end
        no_gaps = 0;
        settle();

        // Close the span: one ending, chosen by the seed.
        sel = $urandom_range(0, 4);
        cs = $urandom_range(0, 12);
        case (sel)
            0: begin
                cfg_write(REG_ARCHIVE_LENGTH, sb.pos + HDR_LEN + cs);
                cfg_valid <= 0;
                good_member(cs, 0, $urandom);
            end
            1: begin
                cfg_write(REG_ARCHIVE_LENGTH, sb.pos + HDR_LEN + cs + TRAILER_LEN);
                cfg_valid <= 0;
                good_member(cs, 0, $urandom);
            end
            2: begin
                cfg_write(REG_ARCHIVE_LENGTH, sb.pos + 60);
                cfg_valid <= 0;
                c = $urandom_range(0, 10);
                case (c)
                    0: send_header(NAME_LEN_BYTE ^ $urandom_range(1, 255), 0, 0, 0, 0, 0,
                                   MARK_BYTE);
                    1: send_header(NAME_LEN_BYTE, 2, 0, 0, 0, 0, MARK_BYTE);
                    2: send_header(NAME_LEN_BYTE, 1, 0, 0, 0, 0, MARK_BYTE);
                    3: send_header(NAME_LEN_BYTE, 0, 0, 0, 0, 0,
                                   MARK_BYTE ^ $urandom_range(1, 255));
                    4: send_header(NAME_LEN_BYTE, 0, 32'h80000000 | $urandom, 0, 1, 0,
                                   MARK_BYTE);
                    5: send_header(NAME_LEN_BYTE, 0, 3, sb.max_sz + 1, 1, 0, MARK_BYTE);
                    6: send_header(NAME_LEN_BYTE, 0, 0, 0, $urandom_range(2, 255), 0,
                                   MARK_BYTE);
                    7: send_header(NAME_LEN_BYTE, 0, 3, 4, 0, 0, MARK_BYTE);
                    8: send_header(NAME_LEN_BYTE, 0, 60, 60, 0, 0, MARK_BYTE);
                    9: send_header(NAME_LEN_BYTE, 0, $urandom_range(0, 2), 7, 1, 0,
                                   MARK_BYTE);
                    default: begin
                        send_header(NAME_LEN_BYTE, 0, 5, 5, 1, 0, MARK_BYTE);
                        p1 = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                  : $urandom_range(7, 255);
                        if ($urandom_range(0, 1)) send_payload(5, 1, $urandom_range(2, 255), 4);
                        else send_payload(5, 1, 0, p1);
                    end
                endcase
            end
            3: begin
                cfg_write(REG_MAX_COUNT, sb.count);
                cfg_write(REG_ARCHIVE_LENGTH, sb.pos + 40);
                cfg_valid <= 0;
            end
            default: begin
                cfg_write(REG_ARCHIVE_LENGTH, sb.pos + HDR_LEN + cs + 3);
                cfg_valid <= 0;
                good_member(cs, 0, $urandom);
            end
        endcase
        // Run out the span, then a few bytes past the verdict that must be dropped.
        while (sb.phase != PH_DONE) send_byte($urandom);
        repeat (3) send_byte($urandom);
        s_valid <= 0;

        while (sb.want.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("install_archive_chain_parser test passed");
        end else begin
            $display("install_archive_chain_parser test failed");
        end
        $finish;
    end

endmodule
